@@ rtl/wspm_pkg.sv @@
// Shared types and constants of the wildcard star pattern matcher.
package wspm_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int CMD_W = 2;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] ANY_BYTE  = 8'h2E;  // '.'
  localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;  // '*'

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_BEGIN  = 2'd2,
    CMD_TEXT   = 2'd3
  } cmd_t;

  // What every cell does with its match bit this cycle
  typedef enum logic [1:0] {
    ROW_HOLD  = 2'd0,
    ROW_EMPTY = 2'd1,
    ROW_TEXT  = 2'd2
  } row_op_t;

  typedef struct packed {
    row_op_t           op;
    logic [BYTE_W-1:0] ch;
  } cell_ctl_t;

endpackage

@@ rtl/wspm_if.sv @@
// Valid/ready channel interfaces for the matcher's input and result items.
interface wspm_in_if;
  import wspm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] ch;
  modport source (output valid, output cmd, output ch, input ready);
  modport sink   (input valid, input cmd, input ch, output ready);
endinterface

interface wspm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic status;
  modport source (output valid, output matched, output status, input ready);
  modport sink   (input valid, input matched, input status, output ready);
endinterface

@@ rtl/wspm_cell.sv @@
// One pattern position: its pattern byte and its bit of the match row.
module wspm_cell import wspm_pkg::*; #(
  parameter bit HAS_PREV = 1'b1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic              wr_en,
  input  logic [BYTE_W-1:0] prev_byte,
  input  logic              left_bit,
  input  logic              far_next,
  output logic [BYTE_W-1:0] pat_byte,
  output logic              bit_q,
  output logic              next_bit
);

  logic [BYTE_W-1:0] pat_r;
  logic              bit_r;
  logic              is_star;
  logic              self_fits;
  logic              prev_fits;

  // Pattern byte as seen this cycle, including a byte being appended
  assign pat_byte = wr_en ? ctl.ch : pat_r;
  assign bit_q    = bit_r;

  assign is_star   = HAS_PREV && (pat_byte == STAR_BYTE);
  assign self_fits = (pat_byte == ANY_BYTE) || (pat_byte == ctl.ch);
  assign prev_fits = HAS_PREV && ((prev_byte == ANY_BYTE) || (prev_byte == ctl.ch));

  // Compute the new match bit from the neighbors two and one places down and from its own bit
  always_comb begin
    case (ctl.op)
      ROW_EMPTY: next_bit = is_star && far_next;
      ROW_TEXT: begin
        if (is_star) next_bit = far_next || (prev_fits && bit_r);
        else         next_bit = self_fits && left_bit;
      end
      default:   next_bit = bit_r;
    endcase
  end

  // Store the pattern byte on append
  always_ff @(posedge clk) begin
    if (wr_en) pat_r <= ctl.ch;
  end

  // Advance the match bit
  always_ff @(posedge clk) begin
    if (!rst_n) bit_r <= 1'b0;
    else        bit_r <= next_bit;
  end

endmodule

@@ rtl/wildcard_star_pattern_matcher.sv @@
// Top level of the wildcard star pattern matcher: command decode, cell row, result register.
//
// Usage: items enter on in_chan (cmd, ch) and each accepted item yields
// exactly one result item on out_chan (matched, status). cmd selects clear
// pattern, append pattern byte, begin new text or text byte. '.' in the
// pattern matches any byte, '*' repeats the element before it.
// One cell per pattern position holds its byte and its match bit; all cells
// update together in the cycle an item is accepted, with the match bits
// rippling through the row from position zero upward.
// Result: registered; it appears in the cycle after the item is accepted.
// Throughput: one item per cycle while in_chan.ready is high.
// Stall: one output register holds the result; in_chan.ready stays high
// while that register is empty or is being taken, and drops while the
// receiver holds off a waiting result.
// Reset: pattern length and match row clear to zero, no result pending;
// the pattern bytes are undefined until appended. Text bytes seen before
// any clear, append or begin-text command never match.
// status is 1 when an append finds the pattern full; the byte is dropped.
module wildcard_star_pattern_matcher import wspm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input logic        clk,
  input logic        rst_n,
  wspm_in_if.sink    in_chan,
  wspm_out_if.source out_chan
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               row0_r, row0_nxt;
  logic [MAX_PATTERN:0] row_q;
  logic [MAX_PATTERN:0] row_nxt;
  logic [BYTE_W-1:0]  pat_eff [1:MAX_PATTERN];
  logic               acc;
  logic               full;
  logic               wr_any;
  logic               drop;
  cell_ctl_t          ctl;
  logic               out_valid_r;
  logic               matched_r;
  logic               status_r;

  assign acc  = in_chan.valid && in_chan.ready;
  assign full = (len_r == LEN_W'(MAX_PATTERN));
  assign in_chan.ready = !out_valid_r || out_chan.ready;

  // Decode the accepted item
  always_comb begin
    ctl.op   = ROW_HOLD;
    ctl.ch   = in_chan.ch;
    len_nxt  = len_r;
    wr_any   = 1'b0;
    drop     = 1'b0;
    if (acc) begin
      unique case (cmd_t'(in_chan.cmd))
        CMD_CLEAR: begin
          ctl.op  = ROW_EMPTY;
          len_nxt = '0;
        end
        CMD_APPEND: begin
          if (full) begin
            drop = 1'b1;
          end else begin
            ctl.op  = ROW_EMPTY;
            len_nxt = len_r + 1'b1;
            wr_any  = 1'b1;
          end
        end
        CMD_BEGIN: ctl.op = ROW_EMPTY;
        CMD_TEXT:  ctl.op = ROW_TEXT;
        default:   ctl.op = ROW_HOLD;
      endcase
    end
  end

  // Position zero matches only the empty text
  always_comb begin
    case (ctl.op)
      ROW_EMPTY: row0_nxt = 1'b1;
      ROW_TEXT:  row0_nxt = 1'b0;
      default:   row0_nxt = row0_r;
    endcase
  end

  assign row_nxt[0] = row0_nxt;
  assign row_q[0]   = row0_r;

  // Row of cells, one per pattern position
  for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
    logic wr_en;
    assign wr_en = wr_any && (len_r == LEN_W'(j - 1));
    if (j == 1) begin : g_first
      wspm_cell #(.HAS_PREV(1'b0)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .wr_en     (wr_en),
        .prev_byte ('0),
        .left_bit  (row_q[j-1]),
        .far_next  (1'b0),
        .pat_byte  (pat_eff[j]),
        .bit_q     (row_q[j]),
        .next_bit  (row_nxt[j])
      );
    end else begin : g_rest
      wspm_cell #(.HAS_PREV(1'b1)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .wr_en     (wr_en),
        .prev_byte (pat_eff[j-1]),
        .left_bit  (row_q[j-1]),
        .far_next  (row_nxt[j-2]),
        .pat_byte  (pat_eff[j]),
        .bit_q     (row_q[j]),
        .next_bit  (row_nxt[j])
      );
    end
  end

  // Advance length and position zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      row0_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      row0_r <= row0_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n)                 out_valid_r <= 1'b0;
    else if (acc)               out_valid_r <= 1'b1;
    else if (out_chan.ready)    out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      matched_r <= row_nxt[len_nxt];
      status_r  <= drop;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.matched = matched_r;
  assign out_chan.status  = status_r;

`ifndef ASSERT_OFF
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_PATTERN))
    else $error("pattern length beyond capacity");

  a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_chan.cmd == CMD_APPEND) && full) |=> (out_chan.status && $stable(len_r)))
    else $error("full append not flagged or length changed");

  a_clear_match: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_chan.cmd == CMD_CLEAR)) |=> (len_r == '0 && out_chan.matched))
    else $error("empty pattern must match empty text");

  a_text_row0: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_chan.cmd == CMD_TEXT)) |=> (!row0_r && !out_chan.status))
    else $error("text byte left position zero set or flagged");

  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("item accepted while result register blocked");
`endif

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench of the wildcard star pattern matcher.
`timescale 1ns / 100ps

module tb;
  import wspm_pkg::*;

  localparam int MAXP       = MAX_PATTERN_DEF;
  localparam int ITEM_COUNT = 1800;
  localparam int HOLD_AT    = 600;
  localparam int PAUSE_AT   = 1100;
  localparam int QUIET_AT   = 1600;
  localparam int LONG_HOLD  = 60;
  localparam int CYCLE_CAP  = 200000;

  typedef struct packed {
    logic matched;
    logic status;
  } verdict_t;

  // One row of the directed table; typed rows carry their own verdict
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] ch;
    logic [4:0] reps;
    logic       typed;
    logic       matched;
    logic       status;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wspm_in_if  in_chan ();
  wspm_out_if out_chan ();

  wildcard_star_pattern_matcher dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Matcher state as the testbench sees it
  logic [7:0]  pat_bytes [MAXP];
  int          pat_len = 0;
  logic [MAXP:0] match_bits = '0;

  verdict_t pending_verdicts [$];
  int       items_sent = 0;
  int       mismatches = 0;
  int       cycles = 0;
  bit       quiet = 1'b0;
  bit       long_hold = 1'b0;

  step_t directed [25] = '{
    '{CMD_TEXT,   8'h61, 5'd1,  1'b1, 1'b0, 1'b0},  // text before any begin
    '{CMD_BEGIN,  8'h00, 5'd1,  1'b1, 1'b1, 1'b0},  // empty pattern, empty text
    '{CMD_CLEAR,  8'hFF, 5'd1,  1'b1, 1'b1, 1'b0},
    '{CMD_TEXT,   8'h00, 5'd1,  1'b1, 1'b0, 1'b0},
    '{CMD_APPEND, 8'h2A, 5'd1,  1'b0, 1'b0, 1'b0},  // leading star
    '{CMD_TEXT,   8'h2A, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_TEXT,   8'h61, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_APPEND, 8'h2A, 5'd1,  1'b0, 1'b0, 1'b0},  // star after star
    '{CMD_TEXT,   8'h2A, 5'd3,  1'b0, 1'b0, 1'b0},
    '{CMD_CLEAR,  8'h00, 5'd1,  1'b1, 1'b1, 1'b0},
    '{CMD_APPEND, 8'h61, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_APPEND, 8'h2A, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_APPEND, 8'h2E, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_TEXT,   8'h61, 5'd2,  1'b0, 1'b0, 1'b0},
    '{CMD_TEXT,   8'hFF, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_BEGIN,  8'h55, 5'd1,  1'b0, 1'b0, 1'b0},  // ch ignored on begin
    '{CMD_CLEAR,  8'h00, 5'd1,  1'b1, 1'b1, 1'b0},
    '{CMD_APPEND, 8'h2E, 5'd8,  1'b0, 1'b0, 1'b0},
    '{CMD_APPEND, 8'h2A, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_APPEND, 8'hFF, 5'd7,  1'b0, 1'b0, 1'b0},  // pattern now full
    '{CMD_APPEND, 8'h00, 5'd1,  1'b1, 1'b0, 1'b1},  // dropped byte
    '{CMD_APPEND, 8'hFF, 5'd1,  1'b1, 1'b0, 1'b1},
    '{CMD_BEGIN,  8'h00, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_TEXT,   8'h00, 5'd7,  1'b0, 1'b0, 1'b0},
    '{CMD_TEXT,   8'hFF, 5'd7,  1'b0, 1'b0, 1'b0}
  };

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic fits(logic [7:0] text_byte, logic [7:0] pat_byte);
    return (pat_byte == ANY_BYTE) || (pat_byte == text_byte);
  endfunction

  // Row for an empty text: stars let bit j follow bit j-2
  function automatic void load_empty_row();
    match_bits = '0;
    match_bits[0] = 1'b1;
    for (int j = 2; j <= pat_len; j++) begin
      if (pat_bytes[j-1] == STAR_BYTE) match_bits[j] = match_bits[j-2];
    end
  endfunction

  // Advance the matcher state by one item and return its verdict
  function automatic verdict_t step_matcher(cmd_t cmd, logic [7:0] ch);
    verdict_t      v;
    logic [MAXP:0] nxt;
    logic          bit_j;
    v.status = 1'b0;
    case (cmd)
      CMD_CLEAR: begin
        pat_len = 0;
        load_empty_row();
      end
      CMD_APPEND: begin
        if (pat_len < MAXP) begin
          pat_bytes[pat_len] = ch;
          pat_len++;
          load_empty_row();
        end else begin
          v.status = 1'b1;
        end
      end
      CMD_BEGIN: begin
        load_empty_row();
      end
      default: begin
        nxt = '0;
        for (int j = 1; j <= pat_len; j++) begin
          bit_j = fits(ch, pat_bytes[j-1]) ? match_bits[j-1] : 1'b0;
          if (j >= 2 && pat_bytes[j-1] == STAR_BYTE) begin
            bit_j = nxt[j-2];
            if (fits(ch, pat_bytes[j-2])) bit_j = bit_j | match_bits[j];
          end
          nxt[j] = bit_j;
        end
        match_bits = nxt;
      end
    endcase
    v.matched = match_bits[pat_len];
    return v;
  endfunction

  // Mostly a small alphabet so that texts hit the pattern often
  function automatic logic [7:0] pick_pat_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h61;
      3, 4:    return 8'h62;
      5:       return ANY_BYTE;
      6, 7:    return STAR_BYTE;
      8:       return 8'h63;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one item, wait for it to be taken, record its expected verdict
  task automatic offer(input cmd_t cmd, input logic [7:0] ch, input bit typed = 1'b0,
                       input bit exp_m = 1'b0, input bit exp_s = 1'b0);
    verdict_t v;
    int       gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      in_chan.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_chan.valid = 1'b1;
    in_chan.cmd   = cmd;
    in_chan.ch    = ch;
    do @(posedge clk); while (!in_chan.ready);
    v = step_matcher(cmd, ch);
    if (typed) begin
      v.matched = exp_m;
      v.status  = exp_s;
    end
    pending_verdicts.push_back(v);
    items_sent++;
  endtask

  // Receiver: random stall bursts, one long hold on request
  initial begin
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_chan.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_chan.ready = 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  // Check each result item against the oldest expected verdict
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result item with no expected verdict waiting");
        mismatches++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (out_chan.matched !== exp_v.matched) begin
          $error("matched: expected %0b, got %0b", exp_v.matched, out_chan.matched);
          mismatches++;
        end
        if (out_chan.status !== exp_v.status) begin
          $error("status: expected %0b, got %0b", exp_v.status, out_chan.status);
          mismatches++;
        end
      end
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [7:0] pat_q [$];
    logic [7:0] txt_q [$];
    logic [7:0] c;
    int         kind, want_len, n, i;
    bit         hold_done, pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.cmd   = CMD_CLEAR;
    in_chan.ch    = 8'h00;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed table
    foreach (directed[r]) begin
      repeat (directed[r].reps)
        offer(directed[r].cmd, directed[r].ch, directed[r].typed,
              directed[r].matched, directed[r].status);
    end

    // Random part: mostly well-formed pattern and text sequences
    while (items_sent < ITEM_COUNT) begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && items_sent >= PAUSE_AT) begin
        @(negedge clk);
        in_chan.valid = 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        pause_done = 1'b1;
      end
      quiet = (items_sent >= QUIET_AT);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // Noise: any command, any byte
        repeat ($urandom_range(1, 6)) offer(cmd_t'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        if (kind != 1) begin
          offer(CMD_CLEAR, 8'($urandom));
          pat_q.delete();
          want_len = ($urandom_range(0, 15) == 0) ? $urandom_range(MAXP, MAXP + 3)
                                                  : $urandom_range(0, 8);
          repeat (want_len) begin
            c = pick_pat_byte();
            pat_q.push_back(c);
            offer(CMD_APPEND, c);
          end
        end
        repeat ($urandom_range(1, 3)) begin
          // Broken sequences sometimes skip the begin-text command
          if (kind != 1 || $urandom_range(0, 1) == 1) offer(CMD_BEGIN, 8'($urandom));
          // Expand the stored pattern into a text that should match
          txt_q.delete();
          n = (pat_q.size() < MAXP) ? pat_q.size() : MAXP;
          i = 0;
          while (i < n) begin
            c = pat_q[i];
            if (i + 1 < n && pat_q[i+1] == STAR_BYTE) begin
              repeat ($urandom_range(0, 3))
                txt_q.push_back((c == ANY_BYTE) ? 8'($urandom) : c);
              i += 2;
            end else begin
              txt_q.push_back((c == ANY_BYTE) ? 8'($urandom) : c);
              i++;
            end
          end
          // Spoil some texts
          if (txt_q.size() > 0 && $urandom_range(0, 3) == 0)
            txt_q[$urandom_range(0, txt_q.size() - 1)] = pick_pat_byte();
          if ($urandom_range(0, 4) == 0) txt_q.push_back(pick_pat_byte());
          foreach (txt_q[k]) offer(CMD_TEXT, txt_q[k]);
        end
      end
    end

    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
